>>> sv/world_to_radar_projection_core_macros.svh
// assertion macros for the radar projection core
`ifndef WORLD_TO_RADAR_PROJECTION_CORE_MACROS_SVH
`define WORLD_TO_RADAR_PROJECTION_CORE_MACROS_SVH

// same-cycle implication
`define W2R_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define W2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/w2r_pkg.sv
// shared types, constants and helpers for the radar projection core
package w2r_pkg;

  typedef enum logic [1:0] {
    KIND_PLAIN     = 2'd0,
    KIND_NAVPOINT  = 2'd1,
    KIND_WORLDSIDE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_SCAN_RADIUS  = 3'd0,
    REG_CENTER_X     = 3'd1,
    REG_CENTER_Y     = 3'd2,
    REG_INNER_RADIUS = 3'd3,
    REG_OUTER_RADIUS = 3'd4
  } reg_idx_e;

  localparam logic [30:0] SCAN_RADIUS_RST = 31'd128000;
  localparam logic [15:0] CENTER_RST      = 16'd16640;
  localparam logic [15:0] RADIUS_RST      = 16'd12544;

  localparam logic signed [55:0] OUT_MAX = 56'sd8388607;
  localparam logic signed [55:0] OUT_MIN = -56'sd8388608;

  function automatic logic [23:0] sat24(input logic signed [55:0] v);
    logic [23:0] r;
    if (v > OUT_MAX) begin
      r = 24'h7FFFFF;
    end else if (v < OUT_MIN) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

>>> sv/w2r_div.sv
// pipelined restoring divider, one quotient bit per stage, with a tag that travels along
module w2r_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic          vld_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [NW-1:0] nq_q   [NW];
  logic [TW-1:0] tag_q  [NW];

  logic          vld_in [NW];
  logic [DW-1:0] den_in [NW];
  logic [TW-1:0] tag_in [NW];
  logic [DW-1:0] rem_d  [NW];
  logic [NW-1:0] nq_d   [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_c;
    logic [NW-1:0] nq_c;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_c     = '0;
      assign nq_c      = num_i;
      assign den_in[k] = den_i;
      assign tag_in[k] = tag_i;
      assign vld_in[k] = valid_i;
    end else begin : g_next
      assign rem_c     = rem_q[k-1];
      assign nq_c      = nq_q[k-1];
      assign den_in[k] = den_q[k-1];
      assign tag_in[k] = tag_q[k-1];
      assign vld_in[k] = vld_q[k-1];
    end

    assign trial    = {rem_c, nq_c[NW-1]};
    assign diff     = trial - {1'b0, den_in[k]};
    assign ge       = (trial >= {1'b0, den_in[k]});
    assign rem_d[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign nq_d[k]  = {nq_c[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NW; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NW; k++) vld_q[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NW; k++) begin
      rem_q[k] <= rem_d[k];
      nq_q[k]  <= nq_d[k];
      den_q[k] <= den_in[k];
      tag_q[k] <= tag_in[k];
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = nq_q[NW-1];
  assign tag_o   = tag_q[NW-1];

endmodule

>>> sv/w2r_sqrt.sv
// pipelined integer square root, one root bit per stage, with a tag that travels along
module w2r_sqrt #(
  parameter int unsigned IW = 64,
  parameter int unsigned TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [IW-1:0]   rad_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [IW/2-1:0] root_o,
  output logic [TW-1:0]   tag_o
);

  localparam int unsigned RW = IW / 2;

  logic          vld_q   [RW];
  logic [IW-1:0] rad_q   [RW];
  logic [RW+1:0] rem_q   [RW];
  logic [RW-1:0] root_q  [RW];
  logic [TW-1:0] tag_q   [RW];

  logic          vld_in  [RW];
  logic [TW-1:0] tag_in  [RW];
  logic [IW-1:0] rad_d   [RW];
  logic [RW+1:0] rem_d   [RW];
  logic [RW-1:0] root_d  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [IW-1:0] rad_c;
    logic [RW+1:0] rem_c;
    logic [RW-1:0] root_c;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rad_c     = rad_i;
      assign rem_c     = '0;
      assign root_c    = '0;
      assign tag_in[k] = tag_i;
      assign vld_in[k] = valid_i;
    end else begin : g_next
      assign rad_c     = rad_q[k-1];
      assign rem_c     = rem_q[k-1];
      assign root_c    = root_q[k-1];
      assign tag_in[k] = tag_q[k-1];
      assign vld_in[k] = vld_q[k-1];
    end

    assign cur       = {rem_c[RW-1:0], rad_c[IW-1:IW-2]};
    assign trial     = {root_c, 2'b01};
    assign ge        = (cur >= trial);
    assign rem_d[k]  = ge ? (cur - trial) : cur;
    assign root_d[k] = {root_c[RW-2:0], ge};
    assign rad_d[k]  = {rad_c[IW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RW; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < RW; k++) vld_q[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RW; k++) begin
      rad_q[k]  <= rad_d[k];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      tag_q[k]  <= tag_in[k];
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

>>> sv/world_to_radar_projection_core.sv
// top level of the world to radar projection core
// throughput: one transaction per cycle, busy stays low; the depth is set by the
// 32-stage square root and the 63-stage and 54-stage restoring divider pipelines
// reset: asynchronous active-low, clears the stage valid bits and loads register defaults
// the receiver cannot stall, so the pipeline never holds
`include "world_to_radar_projection_core_macros.svh"

module world_to_radar_projection_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] object_x_i,
  input  logic signed [31:0] object_y_i,
  input  logic signed [31:0] object_z_i,
  input  logic signed [31:0] viewer_x_i,
  input  logic signed [31:0] viewer_y_i,
  input  logic signed [31:0] viewer_z_i,
  input  logic signed [15:0] heading_x_i,
  input  logic signed [15:0] heading_z_i,
  input  logic [1:0]         item_kind_i,
  input  logic               viewer_present_i,
  output logic               result_valid_o,
  output logic signed [23:0] radar_x_o,
  output logic signed [23:0] radar_y_o,
  output logic               clamped_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [30:0] scan_radius_q;
  logic [15:0] center_x_q, center_y_q, inner_radius_q, outer_radius_q;
  logic        cfg_wr;
  logic [30:0] reff;
  logic [61:0] rr_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign reff   = (scan_radius_q == '0) ? 31'd1 : scan_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_radius_q  <= w2r_pkg::SCAN_RADIUS_RST;
      center_x_q     <= w2r_pkg::CENTER_RST;
      center_y_q     <= w2r_pkg::CENTER_RST;
      inner_radius_q <= w2r_pkg::RADIUS_RST;
      outer_radius_q <= w2r_pkg::RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        w2r_pkg::REG_SCAN_RADIUS:  scan_radius_q  <= pwdata[30:0];
        w2r_pkg::REG_CENTER_X:     center_x_q     <= pwdata[15:0];
        w2r_pkg::REG_CENTER_Y:     center_y_q     <= pwdata[15:0];
        w2r_pkg::REG_INNER_RADIUS: inner_radius_q <= pwdata[15:0];
        w2r_pkg::REG_OUTER_RADIUS: outer_radius_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      w2r_pkg::REG_SCAN_RADIUS:  prdata = {1'b0, scan_radius_q};
      w2r_pkg::REG_CENTER_X:     prdata = {16'd0, center_x_q};
      w2r_pkg::REG_CENTER_Y:     prdata = {16'd0, center_y_q};
      w2r_pkg::REG_INNER_RADIUS: prdata = {16'd0, inner_radius_q};
      w2r_pkg::REG_OUTER_RADIUS: prdata = {16'd0, outer_radius_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rr_q <= reff * reff;
  end

  // stage 1: relative vector
  logic            acc;
  w2r_pkg::kind_e  kind_d;
  logic            s1_v_q;
  logic [32:0]     s1_cx_q, s1_cy_q, s1_cz_q;
  logic signed [15:0] s1_hx_q, s1_hz_q;
  w2r_pkg::kind_e  s1_kind_q;
  logic            s1_vp_q;

  assign acc = start & ~busy;

  always_comb begin
    case (item_kind_i)
      w2r_pkg::KIND_NAVPOINT:  kind_d = w2r_pkg::KIND_NAVPOINT;
      w2r_pkg::KIND_WORLDSIDE: kind_d = w2r_pkg::KIND_WORLDSIDE;
      default:                 kind_d = w2r_pkg::KIND_PLAIN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cx_q   <= {object_x_i[31], object_x_i} - {viewer_x_i[31], viewer_x_i};
    s1_cy_q   <= {object_y_i[31], object_y_i} - {viewer_y_i[31], viewer_y_i};
    s1_cz_q   <= {object_z_i[31], object_z_i} - {viewer_z_i[31], viewer_z_i};
    s1_hx_q   <= heading_x_i;
    s1_hz_q   <= heading_z_i;
    s1_kind_q <= kind_d;
    s1_vp_q   <= viewer_present_i;
  end

  // stage 2: magnitudes, range test, shift for the edge path, heading squares
  logic [32:0] ax, ay, az;
  logic        sh1, sh2;
  logic signed [31:0] hx2, hz2;
  logic        s2_v_q, s2_gt_q, s2_vp_q;
  logic [30:0] s2_ax_q, s2_ay_q, s2_az_q, s2_sx_q, s2_sy_q, s2_sz_q;
  logic [30:0] s2_hx2_q, s2_hz2_q;
  logic [32:0] s2_cx_q, s2_cz_q;
  logic signed [15:0] s2_hx_q, s2_hz_q;
  w2r_pkg::kind_e s2_kind_q;

  assign ax  = s1_cx_q[32] ? (33'd0 - s1_cx_q) : s1_cx_q;
  assign ay  = s1_cy_q[32] ? (33'd0 - s1_cy_q) : s1_cy_q;
  assign az  = s1_cz_q[32] ? (33'd0 - s1_cz_q) : s1_cz_q;
  assign sh2 = ax[32] | ay[32] | az[32];
  assign sh1 = ax[31] | ay[31] | az[31];
  assign hx2 = s1_hx_q * s1_hx_q;
  assign hz2 = s1_hz_q * s1_hz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_gt_q   <= (ax > {2'b00, reff}) || (ay > {2'b00, reff}) || (az > {2'b00, reff});
    s2_ax_q   <= ax[30:0];
    s2_ay_q   <= ay[30:0];
    s2_az_q   <= az[30:0];
    s2_sx_q   <= sh2 ? ax[32:2] : (sh1 ? ax[31:1] : ax[30:0]);
    s2_sy_q   <= sh2 ? ay[32:2] : (sh1 ? ay[31:1] : ay[30:0]);
    s2_sz_q   <= sh2 ? az[32:2] : (sh1 ? az[31:1] : az[30:0]);
    s2_hx2_q  <= hx2[30:0];
    s2_hz2_q  <= hz2[30:0];
    s2_cx_q   <= s1_cx_q;
    s2_cz_q   <= s1_cz_q;
    s2_hx_q   <= s1_hx_q;
    s2_hz_q   <= s1_hz_q;
    s2_kind_q <= s1_kind_q;
    s2_vp_q   <= s1_vp_q;
  end

  // stage 3: squares
  logic        s3_v_q, s3_gt_q, s3_vp_q;
  logic [61:0] s3_qa_q, s3_qb_q, s3_qc_q, s3_pa_q, s3_pb_q, s3_pc_q;
  logic [31:0] s3_hs_q;
  logic [32:0] s3_cx_q, s3_cz_q;
  logic [30:0] s3_sx_q, s3_sz_q;
  logic signed [15:0] s3_hx_q, s3_hz_q;
  w2r_pkg::kind_e s3_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_qa_q   <= s2_ax_q * s2_ax_q;
    s3_qb_q   <= s2_ay_q * s2_ay_q;
    s3_qc_q   <= s2_az_q * s2_az_q;
    s3_pa_q   <= s2_sx_q * s2_sx_q;
    s3_pb_q   <= s2_sy_q * s2_sy_q;
    s3_pc_q   <= s2_sz_q * s2_sz_q;
    s3_hs_q   <= 32'(s2_hx2_q) + 32'(s2_hz2_q);
    s3_gt_q   <= s2_gt_q;
    s3_cx_q   <= s2_cx_q;
    s3_cz_q   <= s2_cz_q;
    s3_sx_q   <= s2_sx_q;
    s3_sz_q   <= s2_sz_q;
    s3_hx_q   <= s2_hx_q;
    s3_hz_q   <= s2_hz_q;
    s3_kind_q <= s2_kind_q;
    s3_vp_q   <= s2_vp_q;
  end

  // stage 4: sums and the edge decision
  logic [63:0] sum3, psum;
  logic        pull_d, hzero_d;
  logic        s4_v_q, s4_pull_q, s4_hzero_q, s4_vp_q;
  logic [63:0] s4_psum_q;
  logic [31:0] s4_hs_q;
  logic [32:0] s4_cx_q, s4_cz_q;
  logic [30:0] s4_sx_q, s4_sz_q;
  logic signed [15:0] s4_hx_q, s4_hz_q;

  assign sum3    = 64'(s3_qa_q) + 64'(s3_qb_q) + 64'(s3_qc_q);
  assign psum    = 64'(s3_pa_q) + 64'(s3_pb_q) + 64'(s3_pc_q);
  assign pull_d  = (s3_kind_q == w2r_pkg::KIND_WORLDSIDE) ||
                   ((s3_kind_q == w2r_pkg::KIND_NAVPOINT) && (s3_gt_q || (sum3 > 64'(rr_q))));
  assign hzero_d = (s3_hx_q == 16'sd0) && (s3_hz_q == 16'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_psum_q  <= psum;
    s4_hs_q    <= s3_hs_q;
    s4_pull_q  <= pull_d;
    s4_hzero_q <= hzero_d;
    s4_cx_q    <= s3_cx_q;
    s4_cz_q    <= s3_cz_q;
    s4_sx_q    <= s3_sx_q;
    s4_sz_q    <= s3_sz_q;
    s4_hx_q    <= s3_hx_q;
    s4_hz_q    <= s3_hz_q;
    s4_vp_q    <= s3_vp_q;
  end

  // square roots: edge length and heading length
  localparam int unsigned SA_TW = 130;
  localparam int unsigned SB_TW = 33;

  logic             sa_v, sb_v;
  logic [31:0]      sa_root, sb_root;
  logic [SA_TW-1:0] sa_tag;
  logic [SB_TW-1:0] sb_tag;

  w2r_sqrt #(.IW(64), .TW(SA_TW)) u_sqrt_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_v_q),
    .rad_i   (s4_psum_q),
    .tag_i   ({s4_cx_q, s4_cz_q, s4_sx_q, s4_sz_q, s4_pull_q, s4_vp_q}),
    .valid_o (sa_v),
    .root_o  (sa_root),
    .tag_o   (sa_tag)
  );

  w2r_sqrt #(.IW(64), .TW(SB_TW)) u_sqrt_head (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_v_q),
    .rad_i   ({s4_hs_q, 32'd0}),
    .tag_i   ({s4_hzero_q, s4_hx_q, s4_hz_q}),
    .valid_o (sb_v),
    .root_o  (sb_root),
    .tag_o   (sb_tag)
  );

  // stage 5: numerators for edge scaling and cos/sin
  logic [32:0] t5_cx, t5_cz;
  logic [30:0] t5_sx, t5_sz;
  logic        t5_pull, t5_vp, t5_hzero;
  logic signed [15:0] t5_hx, t5_hz;
  logic [15:0] hxm, hzm;
  logic [61:0] mulx, mulz;
  logic        s5_v_q, s5_pull_q, s5_vp_q, s5_lz_q, s5_hzero_q, s5_hxn_q, s5_hzn_q;
  logic [62:0] s5_pnx_q, s5_pnz_q, s5_hnc_q, s5_hns_q;
  logic [31:0] s5_len_q, s5_hlen_q;
  logic [32:0] s5_cx_q, s5_cz_q;

  assign {t5_cx, t5_cz, t5_sx, t5_sz, t5_pull, t5_vp} = sa_tag;
  assign {t5_hzero, t5_hx, t5_hz} = sb_tag;
  assign hxm  = t5_hx[15] ? (16'd0 - t5_hx) : t5_hx;
  assign hzm  = t5_hz[15] ? (16'd0 - t5_hz) : t5_hz;
  assign mulx = t5_sx * reff;
  assign mulz = t5_sz * reff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= sa_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_pnx_q   <= 63'(mulx) + 63'(sa_root[31:1]);
    s5_pnz_q   <= 63'(mulz) + 63'(sa_root[31:1]);
    s5_hnc_q   <= 63'({hzm, 31'd0}) + 63'(sb_root[31:1]);
    s5_hns_q   <= 63'({hxm, 31'd0}) + 63'(sb_root[31:1]);
    s5_len_q   <= sa_root;
    s5_hlen_q  <= sb_root;
    s5_lz_q    <= (sa_root == '0);
    s5_hzero_q <= t5_hzero;
    s5_hxn_q   <= t5_hx[15];
    s5_hzn_q   <= t5_hz[15];
    s5_cx_q    <= t5_cx;
    s5_cz_q    <= t5_cz;
    s5_pull_q  <= t5_pull;
    s5_vp_q    <= t5_vp;
  end

  // edge scaling and cos/sin dividers
  localparam int unsigned DX_TW = 72;

  logic             dx_v, dz_v, dc_v, ds_v;
  logic [62:0]      dx_q, dz_q, dc_q, ds_q;
  logic [DX_TW-1:0] dx_tag;

  w2r_div #(.NW(63), .DW(32), .TW(DX_TW)) u_div_ex (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s5_v_q),
    .num_i   (s5_pnx_q),
    .den_i   (s5_len_q),
    .tag_i   ({s5_cx_q, s5_cz_q, s5_pull_q, s5_vp_q, s5_lz_q,
               s5_hzero_q, s5_hxn_q, s5_hzn_q}),
    .valid_o (dx_v),
    .quo_o   (dx_q),
    .tag_o   (dx_tag)
  );

  w2r_div #(.NW(63), .DW(32), .TW(1)) u_div_ez (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s5_v_q),
    .num_i   (s5_pnz_q),
    .den_i   (s5_len_q),
    .tag_i   (1'b0),
    .valid_o (dz_v),
    .quo_o   (dz_q),
    .tag_o   ()
  );

  w2r_div #(.NW(63), .DW(32), .TW(1)) u_div_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s5_v_q),
    .num_i   (s5_hnc_q),
    .den_i   (s5_hlen_q),
    .tag_i   (1'b0),
    .valid_o (dc_v),
    .quo_o   (dc_q),
    .tag_o   ()
  );

  w2r_div #(.NW(63), .DW(32), .TW(1)) u_div_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s5_v_q),
    .num_i   (s5_hns_q),
    .den_i   (s5_hlen_q),
    .tag_i   (1'b0),
    .valid_o (ds_v),
    .quo_o   (ds_q),
    .tag_o   ()
  );

  // stage 6: pick vector, limit cos/sin
  logic [32:0] t6_cx, t6_cz, nxv, nzv;
  logic        t6_pull, t6_vp, t6_lz, t6_hzero, t6_hxn, t6_hzn;
  logic [16:0] csm, snm;
  logic        s6_v_q, s6_pull_q, s6_vp_q;
  logic signed [32:0] s6_cx_q, s6_cz_q;
  logic signed [16:0] s6_cs_q, s6_sn_q;

  assign {t6_cx, t6_cz, t6_pull, t6_vp, t6_lz, t6_hzero, t6_hxn, t6_hzn} = dx_tag;
  assign nxv = t6_cx[32] ? (33'd0 - {1'b0, dx_q[31:0]}) : {1'b0, dx_q[31:0]};
  assign nzv = t6_cz[32] ? (33'd0 - {1'b0, dz_q[31:0]}) : {1'b0, dz_q[31:0]};
  assign csm = (dc_q > 63'd32768) ? 17'd32768 : dc_q[16:0];
  assign snm = (ds_q > 63'd32768) ? 17'd32768 : ds_q[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else begin
      s6_v_q <= dx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_cx_q   <= (t6_pull && !t6_lz) ? nxv : t6_cx;
    s6_cz_q   <= (t6_pull && !t6_lz) ? nzv : t6_cz;
    s6_cs_q   <= t6_hzero ? 17'sd32768 : (t6_hzn ? (17'd0 - csm) : csm);
    s6_sn_q   <= t6_hzero ? 17'sd0 : (t6_hxn ? (17'd0 - snm) : snm);
    s6_pull_q <= t6_pull;
    s6_vp_q   <= t6_vp;
  end

  // stage 7: rotation products
  logic        s7_v_q, s7_pull_q, s7_vp_q;
  logic signed [49:0] s7_p1_q, s7_p2_q, s7_p3_q, s7_p4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_p1_q   <= s6_cx_q * s6_cs_q;
    s7_p2_q   <= s6_cz_q * s6_sn_q;
    s7_p3_q   <= s6_cz_q * s6_cs_q;
    s7_p4_q   <= s6_cx_q * s6_sn_q;
    s7_pull_q <= s6_pull_q;
    s7_vp_q   <= s6_vp_q;
  end

  // stage 8: rotation sums, rounded shift by 15
  logic signed [50:0] ux, uz;
  logic [50:0] uxm, uzm;
  logic [51:0] uxr, uzr;
  logic        s8_v_q, s8_pull_q, s8_vp_q, s8_xn_q, s8_zn_q;
  logic [36:0] s8_rxm_q, s8_rzm_q;

  assign ux  = 51'(s7_p1_q) - 51'(s7_p2_q);
  assign uz  = 51'(s7_p3_q) + 51'(s7_p4_q);
  assign uxm = ux[50] ? (51'd0 - ux) : ux;
  assign uzm = uz[50] ? (51'd0 - uz) : uz;
  assign uxr = (52'(uxm) + 52'd16384) >> 15;
  assign uzr = (52'(uzm) + 52'd16384) >> 15;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s8_rxm_q  <= uxr[36:0];
    s8_rzm_q  <= uzr[36:0];
    s8_xn_q   <= ux[50];
    s8_zn_q   <= uz[50];
    s8_pull_q <= s7_pull_q;
    s8_vp_q   <= s7_vp_q;
  end

  // stage 9: display radius product
  logic [15:0] wsel;
  logic        s9_v_q, s9_pull_q, s9_vp_q, s9_xn_q, s9_zn_q;
  logic [53:0] s9_nx_q, s9_nz_q;

  assign wsel = s8_pull_q ? outer_radius_q : inner_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q <= 1'b0;
    end else begin
      s9_v_q <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s9_nx_q   <= 54'(s8_rxm_q) * 54'(wsel) + 54'(reff[30:1]);
    s9_nz_q   <= 54'(s8_rzm_q) * 54'(wsel) + 54'(reff[30:1]);
    s9_xn_q   <= s8_xn_q;
    s9_zn_q   <= s8_zn_q;
    s9_pull_q <= s8_pull_q;
    s9_vp_q   <= s8_vp_q;
  end

  // scale dividers
  logic        vx_v, vz_v;
  logic [53:0] vx_q, vz_q;
  logic [3:0]  vx_tag;

  w2r_div #(.NW(54), .DW(31), .TW(4)) u_div_vx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s9_v_q),
    .num_i   (s9_nx_q),
    .den_i   (reff),
    .tag_i   ({s9_xn_q, s9_zn_q, s9_pull_q, s9_vp_q}),
    .valid_o (vx_v),
    .quo_o   (vx_q),
    .tag_o   (vx_tag)
  );

  w2r_div #(.NW(54), .DW(31), .TW(1)) u_div_vz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s9_v_q),
    .num_i   (s9_nz_q),
    .den_i   (reff),
    .tag_i   (1'b0),
    .valid_o (vz_v),
    .quo_o   (vz_q),
    .tag_o   ()
  );

  // output stage: offset to center and saturate, or zero when no viewer is present
  logic        t_xn, t_zn, t_pull, t_vp;
  logic signed [55:0] vxs, vzs, vx, vz, px, py;
  logic        out_v_q, out_cl_q;
  logic [23:0] out_x_q, out_y_q;

  assign {t_xn, t_zn, t_pull, t_vp} = vx_tag;
  assign vxs = $signed(56'(vx_q));
  assign vzs = $signed(56'(vz_q));
  assign vx  = t_xn ? -vxs : vxs;
  assign vz  = t_zn ? -vzs : vzs;
  assign px  = $signed(56'(center_x_q)) + vx;
  assign py  = $signed(56'(center_y_q)) - vz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= vx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q  <= t_vp ? w2r_pkg::sat24(px) : 24'd0;
    out_y_q  <= t_vp ? w2r_pkg::sat24(py) : 24'd0;
    out_cl_q <= t_vp & t_pull;
  end

  assign result_valid_o = out_v_q;
  assign radar_x_o      = out_x_q;
  assign radar_y_o      = out_y_q;
  assign clamped_o      = out_cl_q;

  // checks
  `W2R_ASSERT_IMPL(a_worldside_pulls, s3_v_q && (s3_kind_q == w2r_pkg::KIND_WORLDSIDE), pull_d, "worldside item not pulled to edge")
  `W2R_ASSERT_IMPL(a_sqrt_aligned, sa_v, sb_v, "square root units out of step")
  `W2R_ASSERT_IMPL(a_rot_div_aligned, dx_v, dz_v && dc_v && ds_v, "edge and heading dividers out of step")
  `W2R_ASSERT_NEXT(a_scale_to_out, vx_v && vz_v, result_valid_o, "scaled transaction not presented")

endmodule
